### rtl/core/rfa_pkg.sv
package rfa_pkg;

	localparam int unsigned IO_BITS = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef enum logic [2:0] {
		MS_CMP1,
		MS_CMP2,
		MS_LCM,
		MS_T1,
		MS_T2,
		MS_NUM,
		MS_DEN
	} mul_sel_t;

	typedef enum logic [1:0] {
		DS_PART,
		DS_M1,
		DS_RN,
		DS_RD
	} div_sel_t;

	typedef enum logic {
		GS_DEN,
		GS_RED
	} gcd_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     div_go;
		div_sel_t div_sel;
		logic     gcd_go;
		gcd_sel_t gcd_sel;
		logic     sum;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic       busy;
		logic       ovf;
		logic       dz;
		logic       out_full;
		logic [2:0] op;
	} dp_stat_t;

endpackage

### rtl/core/rfa_if.sv
interface rfa_in_if;
	import rfa_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [IO_BITS-1:0] a_num;
	logic [IO_BITS-1:0] a_den;
	logic [IO_BITS-1:0] b_num;
	logic [IO_BITS-1:0] b_den;

	modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
	import rfa_pkg::*;
	logic               valid;
	logic               ready;
	logic [IO_BITS-1:0] res_num;
	logic [IO_BITS-1:0] res_den;
	logic [1:0]         status;
	logic               is_less;
	logic               is_equal;
	logic               is_greater;

	modport source (output valid, res_num, res_den, status, is_less, is_equal, is_greater,
		input ready);
	modport sink (input valid, res_num, res_den, status, is_less, is_equal, is_greater,
		output ready);
endinterface

### rtl/core/rfa_ctrl.sv
module rfa_ctrl
	import rfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_C1, S_C2,
		S_AG, S_AD1, S_AD2, S_AL, S_AT1, S_AT2, S_SUM,
		S_MN, S_MD,
		S_RG, S_RN, S_RD,
		S_DONE
	} state_t;

	state_t   state_q;
	ctl_cmd_t cmd_q;
	logic     pend;
	logic     ok;

	assign pend = cmd_q.load | cmd_q.mul_go | cmd_q.div_go | cmd_q.gcd_go | cmd_q.sum |
		cmd_q.out_load;
	assign ok = !stat.busy && !pend;
	assign in_ready = (state_q == S_IDLE);

	// operands are captured at the accepting edge
	always_comb begin
		cmd = cmd_q;
		cmd.load = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
		end else begin
			cmd_q <= '0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q.load <= 1'b1;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (ok) begin
						case (stat.op)
							OP_CMP: begin
								cmd_q.mul_go <= 1'b1;
								cmd_q.mul_sel <= MS_CMP1;
								state_q <= S_C1;
							end
							OP_ADD, OP_SUB: begin
								if (stat.dz) begin
									state_q <= S_DONE;
								end else begin
									cmd_q.gcd_go <= 1'b1;
									cmd_q.gcd_sel <= GS_DEN;
									state_q <= S_AG;
								end
							end
							OP_MUL, OP_DIV: begin
								if (stat.dz) begin
									state_q <= S_DONE;
								end else begin
									cmd_q.mul_go <= 1'b1;
									cmd_q.mul_sel <= MS_NUM;
									state_q <= S_MN;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_C1: begin
					if (ok) begin
						cmd_q.mul_go <= 1'b1;
						cmd_q.mul_sel <= MS_CMP2;
						state_q <= S_C2;
					end
				end
				S_C2: begin
					if (ok) state_q <= S_DONE;
				end
				S_AG: begin
					if (ok) begin
						cmd_q.div_go <= 1'b1;
						cmd_q.div_sel <= DS_PART;
						state_q <= S_AD1;
					end
				end
				S_AD1: begin
					if (ok) begin
						cmd_q.div_go <= 1'b1;
						cmd_q.div_sel <= DS_M1;
						state_q <= S_AD2;
					end
				end
				S_AD2: begin
					if (ok) begin
						cmd_q.mul_go <= 1'b1;
						cmd_q.mul_sel <= MS_LCM;
						state_q <= S_AL;
					end
				end
				S_AL: begin
					if (ok) begin
						if (stat.ovf) begin
							state_q <= S_DONE;
						end else begin
							cmd_q.mul_go <= 1'b1;
							cmd_q.mul_sel <= MS_T1;
							state_q <= S_AT1;
						end
					end
				end
				S_AT1: begin
					if (ok) begin
						if (stat.ovf) begin
							state_q <= S_DONE;
						end else begin
							cmd_q.mul_go <= 1'b1;
							cmd_q.mul_sel <= MS_T2;
							state_q <= S_AT2;
						end
					end
				end
				S_AT2: begin
					if (ok) begin
						if (stat.ovf) begin
							state_q <= S_DONE;
						end else begin
							cmd_q.sum <= 1'b1;
							state_q <= S_SUM;
						end
					end
				end
				S_SUM, S_MD: begin
					if (ok) begin
						if (stat.ovf) begin
							state_q <= S_DONE;
						end else begin
							cmd_q.gcd_go <= 1'b1;
							cmd_q.gcd_sel <= GS_RED;
							state_q <= S_RG;
						end
					end
				end
				S_MN: begin
					if (ok) begin
						if (stat.ovf) begin
							state_q <= S_DONE;
						end else begin
							cmd_q.mul_go <= 1'b1;
							cmd_q.mul_sel <= MS_DEN;
							state_q <= S_MD;
						end
					end
				end
				S_RG: begin
					if (ok) begin
						cmd_q.div_go <= 1'b1;
						cmd_q.div_sel <= DS_RN;
						state_q <= S_RN;
					end
				end
				S_RN: begin
					if (ok) begin
						cmd_q.div_go <= 1'b1;
						cmd_q.div_sel <= DS_RD;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (ok) state_q <= S_DONE;
				end
				S_DONE: begin
					if (ok && !stat.out_full) begin
						cmd_q.out_load <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/rfa_dpath.sv
module rfa_dpath
	import rfa_pkg::*;
#(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         req_type,
	input  logic [IO_BITS-1:0] a_num,
	input  logic [IO_BITS-1:0] a_den,
	input  logic [IO_BITS-1:0] b_num,
	input  logic [IO_BITS-1:0] b_den,
	rfa_out_if.source          rsp
);

	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned CW = $clog2(W);

	logic [2:0]   op_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic         dz_q, ovf_q;
	logic [W-1:0] g_q, part_q, m1_q, lcm_q, t1_q, t2_q, n_q, d_q;
	logic         nneg_q, dneg_q;
	logic signed [PW:0] p1_q, p2_q;

	// operand signs and magnitudes
	logic         an_neg, ad_neg, bn_neg, bd_neg, f1_neg, f2_neg;
	logic [W-1:0] anm, adm, bnm, bdm, f1m, f2m;

	assign an_neg = an_q[W-1];
	assign ad_neg = ad_q[W-1];
	assign bn_neg = bn_q[W-1];
	assign bd_neg = bd_q[W-1];
	assign anm = an_neg ? W'(0) - an_q : an_q;
	assign adm = ad_neg ? W'(0) - ad_q : ad_q;
	assign bnm = bn_neg ? W'(0) - bn_q : bn_q;
	assign bdm = bd_neg ? W'(0) - bd_q : bd_q;
	assign f1_neg = (op_q == OP_MUL) ? bn_neg : bd_neg;
	assign f2_neg = (op_q == OP_MUL) ? bd_neg : bn_neg;
	assign f1m = (op_q == OP_MUL) ? bnm : bdm;
	assign f2m = (op_q == OP_MUL) ? bdm : bnm;

	// shift-add multiplier
	logic          mul_busy_q;
	mul_sel_t      mul_sel_q;
	logic [PW-1:0] mul_a_q, mul_acc_q, mul_acc_n;
	logic [W-1:0]  mul_b_q;
	logic [CW-1:0] mul_cnt_q;
	logic [W-1:0]  mul_x, mul_y;
	logic          mul_hi;
	logic [PW:0]   mul_ext;

	always_comb begin
		case (cmd.mul_sel)
			MS_CMP1: begin mul_x = anm;    mul_y = bdm; end
			MS_CMP2: begin mul_x = bnm;    mul_y = adm; end
			MS_LCM:  begin mul_x = part_q; mul_y = bdm; end
			MS_T1:   begin mul_x = anm;    mul_y = m1_q; end
			MS_T2:   begin mul_x = bnm;    mul_y = part_q; end
			MS_NUM:  begin mul_x = anm;    mul_y = f1m; end
			MS_DEN:  begin mul_x = adm;    mul_y = f2m; end
			default: begin mul_x = anm;    mul_y = bdm; end
		endcase
	end

	assign mul_acc_n = mul_acc_q + (mul_b_q[0] ? mul_a_q : PW'(0));
	assign mul_hi = |mul_acc_n[PW-1:W-1];
	assign mul_ext = {1'b0, mul_acc_n};

	// restoring divider
	logic          div_busy_q;
	div_sel_t      div_sel_q;
	logic [W-1:0]  div_q_q, div_r_q, div_v_q, div_x, div_qn, div_rn;
	logic [CW-1:0] div_cnt_q;
	logic [W:0]    div_sh, div_sub;
	logic          div_ge;

	always_comb begin
		case (cmd.div_sel)
			DS_PART: div_x = adm;
			DS_M1:   div_x = bdm;
			DS_RN:   div_x = n_q;
			DS_RD:   div_x = d_q;
			default: div_x = adm;
		endcase
	end

	assign div_sh = {div_r_q, div_q_q[W-1]};
	assign div_sub = div_sh - {1'b0, div_v_q};
	assign div_ge = (div_sh >= {1'b0, div_v_q});
	assign div_rn = div_ge ? div_sub[W-1:0] : div_sh[W-1:0];
	assign div_qn = {div_q_q[W-2:0], div_ge};

	// binary gcd
	logic          gcd_busy_q;
	logic [W-1:0]  gx_q, gy_q, gcd_x, gcd_y, gcd_res;
	logic [CW-1:0] gk_q;
	logic          gcd_end;

	assign gcd_x = (cmd.gcd_sel == GS_DEN) ? adm : n_q;
	assign gcd_y = (cmd.gcd_sel == GS_DEN) ? bdm : d_q;
	assign gcd_end = (gx_q == W'(0)) || (gy_q == W'(0));
	assign gcd_res = ((gx_q == W'(0)) ? gy_q : gx_q) << gk_q;

	// sum of the scaled numerators
	logic [W:0]   sum_w;
	logic         n1, n2;
	assign sum_w = {1'b0, t1_q} + {1'b0, t2_q};
	assign n1 = an_neg ^ ad_neg;
	assign n2 = bn_neg ^ bd_neg ^ (op_q == OP_SUB);

	// result formatting
	logic         nn, both;
	logic [W-1:0] num_w, den_w;
	logic         dz_in;

	assign nn = nneg_q & (n_q != W'(0));
	assign both = nn & dneg_q;
	assign num_w = (nn & !both) ? W'(0) - n_q : n_q;
	assign den_w = (dneg_q & !both) ? W'(0) - d_q : d_q;
	assign dz_in = (req_type <= OP_DIV) && ((a_den[W-1:0] == W'(0)) ||
		(b_den[W-1:0] == W'(0)) || ((req_type == OP_DIV) && (b_num[W-1:0] == W'(0))));

	assign stat.busy = mul_busy_q | div_busy_q | gcd_busy_q;
	assign stat.ovf = ovf_q;
	assign stat.dz = dz_q;
	assign stat.out_full = rsp.valid;
	assign stat.op = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			div_busy_q <= 1'b0;
			gcd_busy_q <= 1'b0;
			ovf_q <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (cmd.load) ovf_q <= 1'b0;
			if (cmd.mul_go) begin
				mul_busy_q <= 1'b1;
			end else if (mul_busy_q && mul_cnt_q == CW'(0)) begin
				mul_busy_q <= 1'b0;
				if (mul_sel_q != MS_CMP1 && mul_sel_q != MS_CMP2 && mul_hi) ovf_q <= 1'b1;
			end
			if (cmd.div_go) begin
				div_busy_q <= 1'b1;
			end else if (div_busy_q && div_cnt_q == CW'(0)) begin
				div_busy_q <= 1'b0;
			end
			if (cmd.gcd_go) begin
				gcd_busy_q <= 1'b1;
			end else if (gcd_busy_q && gcd_end) begin
				gcd_busy_q <= 1'b0;
			end
			if (cmd.sum && (sum_w[W:W-1] != 2'b00)) ovf_q <= 1'b1;
			if (cmd.out_load) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req_type;
			an_q <= a_num[W-1:0];
			ad_q <= a_den[W-1:0];
			bn_q <= b_num[W-1:0];
			bd_q <= b_den[W-1:0];
			dz_q <= dz_in;
		end
		// multiplier
		if (cmd.mul_go) begin
			mul_sel_q <= cmd.mul_sel;
			mul_a_q <= {W'(0), mul_x};
			mul_b_q <= mul_y;
			mul_acc_q <= '0;
			mul_cnt_q <= CW'(W - 1);
		end else if (mul_busy_q) begin
			mul_acc_q <= mul_acc_n;
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
			mul_cnt_q <= mul_cnt_q - CW'(1);
			if (mul_cnt_q == CW'(0)) begin
				case (mul_sel_q)
					MS_CMP1: p1_q <= (an_neg ^ bd_neg) ? -$signed(mul_ext) : $signed(mul_ext);
					MS_CMP2: p2_q <= (bn_neg ^ ad_neg) ? -$signed(mul_ext) : $signed(mul_ext);
					MS_LCM:  lcm_q <= mul_acc_n[W-1:0];
					MS_T1:   t1_q <= mul_acc_n[W-1:0];
					MS_T2:   t2_q <= mul_acc_n[W-1:0];
					MS_NUM: begin
						n_q <= mul_acc_n[W-1:0];
						nneg_q <= an_neg ^ f1_neg;
					end
					MS_DEN: begin
						d_q <= mul_acc_n[W-1:0];
						dneg_q <= ad_neg ^ f2_neg;
					end
					default: lcm_q <= mul_acc_n[W-1:0];
				endcase
			end
		end
		// divider
		if (cmd.div_go) begin
			div_sel_q <= cmd.div_sel;
			div_q_q <= div_x;
			div_r_q <= '0;
			div_v_q <= g_q;
			div_cnt_q <= CW'(W - 1);
		end else if (div_busy_q) begin
			div_q_q <= div_qn;
			div_r_q <= div_rn;
			div_cnt_q <= div_cnt_q - CW'(1);
			if (div_cnt_q == CW'(0)) begin
				case (div_sel_q)
					DS_PART: part_q <= div_qn;
					DS_M1:   m1_q <= div_qn;
					DS_RN:   n_q <= div_qn;
					DS_RD:   d_q <= div_qn;
					default: part_q <= div_qn;
				endcase
			end
		end
		// gcd
		if (cmd.gcd_go) begin
			gx_q <= gcd_x;
			gy_q <= gcd_y;
			gk_q <= '0;
		end else if (gcd_busy_q) begin
			if (gcd_end) begin
				g_q <= gcd_res;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + CW'(1);
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= gx_q - gy_q;
			end else begin
				gy_q <= gy_q - gx_q;
			end
		end
		if (cmd.sum) begin
			d_q <= lcm_q;
			dneg_q <= 1'b0;
			if (n1 == n2) begin
				n_q <= sum_w[W-1:0];
				nneg_q <= n1;
			end else if (t1_q >= t2_q) begin
				n_q <= t1_q - t2_q;
				nneg_q <= n1;
			end else begin
				n_q <= t2_q - t1_q;
				nneg_q <= n2;
			end
		end
		// result word
		if (cmd.out_load) begin
			rsp.res_num <= '0;
			rsp.res_den <= '0;
			rsp.status <= ST_OK;
			rsp.is_less <= 1'b0;
			rsp.is_equal <= 1'b0;
			rsp.is_greater <= 1'b0;
			if (op_q == OP_CMP) begin
				rsp.is_less <= (p1_q < p2_q);
				rsp.is_greater <= (p1_q > p2_q);
				rsp.is_equal <= (an_q == bn_q) && (ad_q == bd_q);
			end else if (op_q <= OP_DIV) begin
				if (dz_q) begin
					rsp.status <= ST_DZ;
				end else if (ovf_q) begin
					rsp.status <= ST_OVF;
				end else begin
					rsp.res_num <= IO_BITS'($signed(num_w));
					rsp.res_den <= IO_BITS'($signed(den_w));
				end
			end
		end
	end

endmodule

### rtl/core/rational_fraction_alu.sv
// Signed fraction ALU: add, subtract, multiply, divide and compare of two fractions, one
// request word at a time. Operands are taken from the low WORD_BITS bits of each field as
// signed values; arithmetic results come back sign-extended, reduced by their gcd, with an
// overflow or division-by-zero status. All work runs through one bit-serial multiplier, one
// restoring divider and one binary gcd unit; the multiplier and divider each take one bit
// per cycle. Add, subtract, multiply and divide finish early on overflow, a zero denominator
// or a zero divisor. A finished result waits in the output register while the next request
// is taken.
module rational_fraction_alu
	import rfa_pkg::*;
#(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	rfa_in_if.sink    req,
	rfa_out_if.source rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     rdy;

	assign req.ready = rdy;

	rfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (rdy),
		.stat     (stat),
		.cmd      (cmd)
	);

	rfa_dpath #(
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_type (req.req_type),
		.a_num    (req.a_num),
		.a_den    (req.a_den),
		.b_num    (req.b_num),
		.b_den    (req.b_den),
		.rsp      (rsp)
	);

endmodule

### dv/rfa_checker.sv
`timescale 1ns / 100ps

module rfa_checker
	import rfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rfa_in_if.sink     req_mon,
	rfa_out_if.sink    rsp_mon,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic [1:0]  status;
		logic        lt;
		logic        eq;
		logic        gt;
	} frac_result_t;

	localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;

	frac_result_t expected_results[$];

	function automatic logic [63:0] magn(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	function automatic logic mul_fits(logic [63:0] a, logic [63:0] b);
		return (a == 0) || (b <= MAXV / a);
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void reduce_frac(logic nneg, logic [63:0] nm, logic dneg,
		logic [63:0] dm, ref frac_result_t r);
		logic [63:0] g;
		g = gcd64(nm, dm);
		if (g == 0) g = 1;
		nm = nm / g;
		dm = dm / g;
		if (nm == 0) nneg = 1'b0;
		if (nneg && dneg) begin
			nneg = 1'b0;
			dneg = 1'b0;
		end
		r.num = nneg ? -nm : nm;
		r.den = dneg ? -dm : dm;
	endfunction

	function automatic frac_result_t fraction_op(logic [2:0] op, logic [63:0] an,
		logic [63:0] ad, logic [63:0] bn, logic [63:0] bd);
		frac_result_t r;
		logic signed [128:0] c1, c2;
		logic [63:0] adm, bdm, g, part, lcm, m1, m2, anm, bnm, t1, t2, s;
		logic [63:0] f1, f2;
		logic n1, n2, sn;
		r = '0;
		if (op == OP_CMP) begin
			c1 = $signed(an) * $signed(bd);
			c2 = $signed(bn) * $signed(ad);
			r.lt = c1 < c2;
			r.gt = c1 > c2;
			r.eq = (an == bn) && (ad == bd);
		end else if (op <= OP_DIV) begin
			if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
				r.status = ST_DZ;
			end else if (op <= OP_SUB) begin
				adm = magn(ad);
				bdm = magn(bd);
				g = gcd64(adm, bdm);
				part = adm / g;
				if (!mul_fits(part, bdm)) begin
					r.status = ST_OVF;
				end else begin
					lcm = part * bdm;
					m1 = lcm / adm;
					m2 = lcm / bdm;
					anm = magn(an);
					bnm = magn(bn);
					if (!mul_fits(anm, m1) || !mul_fits(bnm, m2) ||
						MAXV - anm * m1 < bnm * m2) begin
						r.status = ST_OVF;
					end else begin
						t1 = anm * m1;
						t2 = bnm * m2;
						n1 = an[63] != ad[63];
						n2 = (bn[63] != bd[63]) != (op == OP_SUB);
						if (n1 == n2) begin
							s = t1 + t2;
							sn = n1;
						end else if (t1 >= t2) begin
							s = t1 - t2;
							sn = n1;
						end else begin
							s = t2 - t1;
							sn = n2;
						end
						reduce_frac(sn, s, 1'b0, lcm, r);
					end
				end
			end else begin
				f1 = (op == OP_MUL) ? bn : bd;
				f2 = (op == OP_MUL) ? bd : bn;
				if (!mul_fits(magn(an), magn(f1)) || !mul_fits(magn(ad), magn(f2))) begin
					r.status = ST_OVF;
				end else begin
					reduce_frac(an[63] != f1[63], magn(an) * magn(f1),
						ad[63] != f2[63], magn(ad) * magn(f2), r);
				end
			end
		end
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		frac_result_t got, want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				expected_results.push_back(fraction_op(req_mon.req_type, req_mon.a_num,
					req_mon.a_den, req_mon.b_num, req_mon.b_den));
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = {rsp_mon.res_num, rsp_mon.res_den, rsp_mon.status,
					rsp_mon.is_less, rsp_mon.is_equal, rsp_mon.is_greater};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch num exp %h act %h den exp %h act %h", $time,
							want.num, got.num, want.den, got.den);
						$display("%0t:   status exp %0d act %0d lt/eq/gt exp %b%b%b act %b%b%b",
							$time, want.status, got.status, want.lt, want.eq, want.gt,
							got.lt, got.eq, got.gt);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### dv/rational_fraction_alu_test.sv
`timescale 1ns / 100ps

module rational_fraction_alu_test;
	import rfa_pkg::*;

	localparam int unsigned N_RANDOM = 600;
	localparam longint unsigned CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned fail_count, pending;
	longint unsigned cycles = 0;
	int unsigned hold_cycles = 0;
	logic stall_mode = 1'b0;
	int unsigned sent = 0;

	rfa_in_if  req ();
	rfa_out_if rsp ();

	rational_fraction_alu u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	rfa_checker u_chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
	endfunction

	// receiver: random stalls, one long hold-off early on
	initial begin
		int unsigned wait_n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles--;
			end else if (!stall_mode) begin
				rsp.ready <= 1'b1;
			end else begin
				wait_n = gap_len();
				if (wait_n == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					hold_cycles = wait_n - 1;
				end
			end
		end
	end

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: w = $signed(w[15:0]);
			1: w = $signed(w[31:0]);
			2: w = $signed(w[7:0]);
			3: w = {1'b1, 63'd0};
			4: w = (w[0]) ? 64'd0 : -64'sd1;
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
		logic [63:0] bn, logic [63:0] bd);
		req.valid <= 1'b1;
		req.req_type <= op;
		req.a_num <= an;
		req.a_den <= ad;
		req.b_num <= bn;
		req.b_den <= bd;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic idle_gap(int unsigned n);
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		logic [63:0] mn, mx;
		logic [2:0] op;
		mn = {1'b1, 63'd0};
		mx = {1'b0, {63{1'b1}}};
		req.valid = 1'b0;
		req.req_type = OP_ADD;
		req.a_num = '0;
		req.a_den = '0;
		req.b_num = '0;
		req.b_den = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
		send_word(OP_SUB, 64'd1, 64'd2, 64'd1, 64'd2);
		send_word(OP_MUL, -64'sd3, 64'd4, 64'd8, -64'sd9);
		send_word(OP_DIV, -64'sd3, -64'sd4, 64'd8, 64'd9);
		send_word(OP_CMP, 64'd1, 64'd2, 64'd2, 64'd4);
		send_word(OP_CMP, mn, mx, mx, mn);
		send_word(OP_ADD, 64'd1, 64'd0, 64'd1, 64'd3);
		send_word(OP_MUL, 64'd1, 64'd2, 64'd1, 64'd0);
		send_word(OP_DIV, 64'd1, 64'd2, 64'd0, 64'd3);
		send_word(OP_ADD, mx, 64'd1, 64'd1, 64'd1);
		send_word(OP_SUB, mn, 64'd1, 64'd1, 64'd1);
		send_word(OP_MUL, mn, 64'd1, 64'd1, 64'd1);
		send_word(OP_MUL, 64'd0, mn, 64'd0, 64'd1);
		send_word(OP_ADD, 64'd0, -64'sd5, 64'd0, 64'd7);
		send_word(OP_ADD, 64'd1, mx, 64'd1, mx - 64'd1);
		send_word(OP_DIV, mx, mx, mn, mn);
		send_word(OP_CMP, mx, mx, mx, mx);
		send_word(3'd5, 64'd1, 64'd1, 64'd1, 64'd1);
		send_word(3'd7, mn, mx, mn, mx);

		// long receiver hold-off while requests keep coming
		hold_cycles = 400;
		repeat (6) send_word(3'($urandom_range(0, 4)), rand_word(), rand_word(), rand_word(),
			rand_word());
		stall_mode = 1'b1;

		repeat (N_RANDOM) begin
			op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(0, 4));
			send_word(op, rand_word(), rand_word(), rand_word(), rand_word());
			if ($urandom_range(0, 2) == 0) idle_gap(gap_len());
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		$display("covered %0d requests: all operations, extreme operands, zero terms,", sent);
		$display("overflow and zero-divisor cases, with random stalls on both sides");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### rational_fraction_alu.f
rtl/core/rfa_pkg.sv
rtl/core/rfa_if.sv
rtl/core/rfa_ctrl.sv
rtl/core/rfa_dpath.sv
rtl/core/rational_fraction_alu.sv
dv/rfa_checker.sv
dv/rational_fraction_alu_test.sv
